// File: rtl/ptc_pkg.sv
// Package with the step codes and the control and status types of the compensation block.
`timescale 1ns / 1ps
package ptc_pkg;

   localparam int RAW_WIDTH = 20;
   localparam int CSR_WIDTH = 64;
   localparam int CSR_INDEX_WIDTH = 2;
   localparam int STEP_WIDTH = 4;

   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_TEMP_CAL = 2'd0;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_PRESS_CAL_A = 2'd1;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_PRESS_CAL_B = 2'd2;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_PRESS_CAL_C = 2'd3;

   localparam logic [STEP_WIDTH-1:0] STEP_T0 = 4'd0;
   localparam logic [STEP_WIDTH-1:0] STEP_T1 = 4'd1;
   localparam logic [STEP_WIDTH-1:0] STEP_T2 = 4'd2;
   localparam logic [STEP_WIDTH-1:0] STEP_P0 = 4'd3;
   localparam logic [STEP_WIDTH-1:0] STEP_P1 = 4'd4;
   localparam logic [STEP_WIDTH-1:0] STEP_P2 = 4'd5;
   localparam logic [STEP_WIDTH-1:0] STEP_P3 = 4'd6;
   localparam logic [STEP_WIDTH-1:0] STEP_P4 = 4'd7;
   localparam logic [STEP_WIDTH-1:0] STEP_P5 = 4'd8;
   localparam logic [STEP_WIDTH-1:0] STEP_P6 = 4'd9;
   localparam logic [STEP_WIDTH-1:0] STEP_P7 = 4'd10;
   localparam logic [STEP_WIDTH-1:0] STEP_P8 = 4'd11;
   localparam logic [STEP_WIDTH-1:0] STEP_P9 = 4'd12;
   localparam logic [STEP_WIDTH-1:0] STEP_P10 = 4'd13;

   typedef struct packed {
      logic load;
      logic start_mul;
      logic start_div;
      logic write_back;
      logic emit;
      logic [STEP_WIDTH-1:0] step;
   } cmd_type;

   typedef struct packed {
      logic mul_done;
      logic div_done;
      logic den_zero;
      logic out_free;
   } status_type;

endpackage

// File: rtl/ptc_req_if.sv
// Interface of the raw sample input channel.
`timescale 1ns / 1ps
interface ptc_req_if;
   logic valid;
   logic ready;
   logic kind;
   logic [19:0] raw_sample;

   modport source(output valid, output kind, output raw_sample, input ready);
   modport sink(input valid, input kind, input raw_sample, output ready);
endinterface

// File: rtl/ptc_rsp_if.sv
// Interface of the compensated result channel.
`timescale 1ns / 1ps
interface ptc_rsp_if;
   logic valid;
   logic ready;
   logic result_kind;
   logic signed [15:0] temperature_hundredths;
   logic [31:0] pressure_q8;
   logic zero_divisor;

   modport source(output valid, output result_kind, output temperature_hundredths,
                  output pressure_q8, output zero_divisor, input ready);
   modport sink(input valid, input result_kind, input temperature_hundredths,
                input pressure_q8, input zero_divisor, output ready);
endinterface

// File: rtl/ptc_mul.sv
// Iterative 64 by 64 bit multiplier, low 64 bits, built from three 32 by 32 bit products.
`timescale 1ns / 1ps
module ptc_mul (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   input  logic [63:0] a,
   input  logic [63:0] b,
   output logic [63:0] result,
   output logic        done
);
   logic [63:0] a_ff, a_in, b_ff, b_in;
   logic [63:0] prod_ff, prod_in, acc_ff, acc_in;
   logic [1:0] cnt_ff, cnt_in;
   logic busy_ff, busy_in, done_ff, done_in;
   logic [31:0] op_x, op_y;

   assign op_x = (cnt_ff == 2'd1) ? a_ff[63:32] : a_ff[31:0];
   assign op_y = (cnt_ff == 2'd2) ? b_ff[63:32] : b_ff[31:0];

   always_comb begin
      a_in = a_ff;
      b_in = b_ff;
      prod_in = prod_ff;
      acc_in = acc_ff;
      cnt_in = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (start) begin
         a_in = a;
         b_in = b;
         cnt_in = 2'd0;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         prod_in = op_x * op_y;
         cnt_in = cnt_ff + 2'd1;
         unique case (cnt_ff)
            2'd0: acc_in = acc_ff;
            2'd1: acc_in = prod_ff;
            2'd2: acc_in = acc_ff + {prod_ff[31:0], 32'd0};
            2'd3: begin
               acc_in = acc_ff + {prod_ff[31:0], 32'd0};
               busy_in = 1'b0;
               done_in = 1'b1;
            end
            default: acc_in = acc_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      a_ff <= a_in;
      b_ff <= b_in;
      prod_ff <= prod_in;
      acc_ff <= acc_in;
      if (reset) begin
         cnt_ff <= 2'd0;
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         cnt_ff <= cnt_in;
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   assign result = acc_ff;
   assign done = done_ff;
endmodule

// File: rtl/ptc_div.sv
// Signed 64-bit restoring divider, one quotient bit per cycle, truncating toward zero.
`timescale 1ns / 1ps
module ptc_div (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   input  logic [63:0] a,
   input  logic [63:0] b,
   output logic [63:0] result,
   output logic        done
);
   logic [63:0] q_ff, q_in, rem_ff, rem_in, ub_ff, ub_in;
   logic neg_ff, neg_in;
   logic [5:0] cnt_ff, cnt_in;
   logic busy_ff, busy_in, done_ff, done_in;
   logic [63:0] rem_sh;

   assign rem_sh = {rem_ff[62:0], q_ff[63]};

   always_comb begin
      q_in = q_ff;
      rem_in = rem_ff;
      ub_in = ub_ff;
      neg_in = neg_ff;
      cnt_in = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (start) begin
         q_in = a[63] ? (64'd0 - a) : a;
         ub_in = b[63] ? (64'd0 - b) : b;
         neg_in = a[63] ^ b[63];
         rem_in = 64'd0;
         cnt_in = 6'd0;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         if (rem_sh >= ub_ff) begin
            rem_in = rem_sh - ub_ff;
            q_in = {q_ff[62:0], 1'b1};
         end else begin
            rem_in = rem_sh;
            q_in = {q_ff[62:0], 1'b0};
         end
         cnt_in = cnt_ff + 6'd1;
         if (cnt_ff == 6'd63) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      q_ff <= q_in;
      rem_ff <= rem_in;
      ub_ff <= ub_in;
      neg_ff <= neg_in;
      if (reset) begin
         cnt_ff <= 6'd0;
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         cnt_ff <= cnt_in;
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   assign result = neg_ff ? (64'd0 - q_ff) : q_ff;
   assign done = done_ff;
endmodule

// File: rtl/ptc_datapath.sv
// Datapath with calibration registers, working registers, shared multiplier and divider.
`timescale 1ns / 1ps
module ptc_datapath (
   input  logic                                 clock,
   input  logic                                 reset,
   input  ptc_pkg::cmd_type                     cmd,
   output ptc_pkg::status_type                  status,
   input  logic                                 req_kind,
   input  logic [ptc_pkg::RAW_WIDTH-1:0]        req_raw_sample,
   input  logic                                 csr_we,
   input  logic [ptc_pkg::CSR_INDEX_WIDTH-1:0]  csr_index,
   input  logic [ptc_pkg::CSR_WIDTH-1:0]        csr_wdata,
   ptc_rsp_if.source                            rsp_if
);
   import ptc_pkg::*;

   logic [47:0] temp_cal_ff;
   logic [63:0] press_cal_a_ff, press_cal_b_ff;
   logic [15:0] press_cal_c_ff;
   logic [31:0] fine_ff;
   logic kind_ff, zero_ff;
   logic [19:0] adc_ff;
   logic [63:0] sq_ff, ra_ff, v2_ff, den_ff, num_ff, p_ff, pt_ff;
   logic [31:0] pfin_ff;
   logic out_valid_ff, out_kind_ff, out_zero_ff;
   logic signed [15:0] out_temp_ff;
   logic [31:0] out_press_ff;

   logic [63:0] t1, t2, t3, p1, p2, p3, p4, p5, p6, p7, p8, p9, ev;
   logic [63:0] op_a, op_b, mres, dres, tf, pf;
   logic signed [63:0] mres_s, p_s;
   logic signed [35:0] f36;
   logic signed [27:0] tsh;
   logic signed [15:0] tsat;
   logic mul_done, div_done, den_zero;

   ptc_mul u_mul (.clock(clock), .reset(reset), .start(cmd.start_mul), .a(op_a), .b(op_b),
                  .result(mres), .done(mul_done));
   ptc_div u_div (.clock(clock), .reset(reset), .start(cmd.start_div), .a(num_ff),
                  .b(den_ff), .result(dres), .done(div_done));

   assign t1 = {48'd0, temp_cal_ff[15:0]};
   assign t2 = {{48{temp_cal_ff[31]}}, temp_cal_ff[31:16]};
   assign t3 = {{48{temp_cal_ff[47]}}, temp_cal_ff[47:32]};
   assign p1 = {48'd0, press_cal_a_ff[15:0]};
   assign p2 = {{48{press_cal_a_ff[31]}}, press_cal_a_ff[31:16]};
   assign p3 = {{48{press_cal_a_ff[47]}}, press_cal_a_ff[47:32]};
   assign p4 = {{48{press_cal_a_ff[63]}}, press_cal_a_ff[63:48]};
   assign p5 = {{48{press_cal_b_ff[15]}}, press_cal_b_ff[15:0]};
   assign p6 = {{48{press_cal_b_ff[31]}}, press_cal_b_ff[31:16]};
   assign p7 = {{48{press_cal_b_ff[47]}}, press_cal_b_ff[47:32]};
   assign p8 = {{48{press_cal_b_ff[63]}}, press_cal_b_ff[63:48]};
   assign p9 = {{48{press_cal_c_ff[15]}}, press_cal_c_ff};
   assign ev = {{32{fine_ff[31]}}, fine_ff} - 64'd128000;
   assign mres_s = $signed(mres);
   assign p_s = $signed(p_ff);

   always_comb begin
      op_a = 64'd0;
      op_b = 64'd0;
      unique case (cmd.step)
         STEP_T0: begin
            op_a = {47'd0, adc_ff[19:3]} - {47'd0, temp_cal_ff[15:0], 1'b0};
            op_b = t2;
         end
         STEP_T1: begin
            op_a = {48'd0, adc_ff[19:4]} - t1;
            op_b = op_a;
         end
         STEP_T2: begin
            op_a = sq_ff;
            op_b = t3;
         end
         STEP_P0: begin
            op_a = ev;
            op_b = ev;
         end
         STEP_P1: begin
            op_a = sq_ff;
            op_b = p6;
         end
         STEP_P2: begin
            op_a = ev;
            op_b = p5;
         end
         STEP_P3: begin
            op_a = sq_ff;
            op_b = p3;
         end
         STEP_P4: begin
            op_a = ev;
            op_b = p2;
         end
         STEP_P5: begin
            op_a = (64'd1 << 47) + ra_ff;
            op_b = p1;
         end
         STEP_P6: begin
            op_a = ((64'd1048576 - {44'd0, adc_ff}) << 31) - v2_ff;
            op_b = 64'd3125;
         end
         STEP_P8: begin
            op_a = p9;
            op_b = $unsigned(p_s >>> 13);
         end
         STEP_P9: begin
            op_a = pt_ff;
            op_b = $unsigned(p_s >>> 13);
         end
         STEP_P10: begin
            op_a = p8;
            op_b = p_ff;
         end
         default: begin
            op_a = 64'd0;
            op_b = 64'd0;
         end
      endcase
   end

   assign tf = ra_ff + $unsigned(mres_s >>> 14);
   assign pf = $unsigned($signed(p_ff + ra_ff + $unsigned(mres_s >>> 19)) >>> 8) + (p7 << 4);
   assign den_zero = (mres[63:33] == 31'd0);

   assign f36 = ($signed({{4{fine_ff[31]}}, fine_ff}) <<< 2)
                + $signed({{4{fine_ff[31]}}, fine_ff}) + 36'sd128;
   assign tsh = f36[35:8];
   always_comb begin
      if (tsh > 28'sd32767) begin
         tsat = 16'sh7fff;
      end else if (tsh < -28'sd32768) begin
         tsat = 16'sh8000;
      end else begin
         tsat = tsh[15:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         temp_cal_ff <= 48'd0;
         press_cal_a_ff <= 64'd0;
         press_cal_b_ff <= 64'd0;
         press_cal_c_ff <= 16'd0;
         fine_ff <= 32'd0;
      end else begin
         if (csr_we) begin
            unique case (csr_index)
               CSR_TEMP_CAL: temp_cal_ff <= csr_wdata[47:0];
               CSR_PRESS_CAL_A: press_cal_a_ff <= csr_wdata;
               CSR_PRESS_CAL_B: press_cal_b_ff <= csr_wdata;
               CSR_PRESS_CAL_C: press_cal_c_ff <= csr_wdata[15:0];
               default: press_cal_c_ff <= press_cal_c_ff;
            endcase
         end
         if (cmd.write_back && cmd.step == STEP_T2) begin
            fine_ff <= tf[31:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         kind_ff <= req_kind;
         adc_ff <= req_raw_sample;
         zero_ff <= 1'b0;
      end
      if (cmd.write_back) begin
         unique case (cmd.step)
            STEP_T0: ra_ff <= $unsigned(mres_s >>> 11);
            STEP_T1: sq_ff <= $unsigned(mres_s >>> 12);
            STEP_T2: ra_ff <= tf;
            STEP_P0: sq_ff <= mres;
            STEP_P1: v2_ff <= mres;
            STEP_P2: v2_ff <= v2_ff + (mres << 17) + (p4 << 35);
            STEP_P3: ra_ff <= $unsigned(mres_s >>> 8);
            STEP_P4: ra_ff <= ra_ff + (mres << 12);
            STEP_P5: begin
               den_ff <= $unsigned(mres_s >>> 33);
               zero_ff <= den_zero;
            end
            STEP_P6: num_ff <= mres;
            STEP_P7: p_ff <= dres;
            STEP_P8: pt_ff <= mres;
            STEP_P9: ra_ff <= $unsigned(mres_s >>> 25);
            STEP_P10: pfin_ff <= pf[31:0];
            default: pt_ff <= pt_ff;
         endcase
      end
      if (cmd.emit) begin
         out_kind_ff <= kind_ff;
         out_temp_ff <= kind_ff ? 16'sd0 : tsat;
         out_press_ff <= (kind_ff && !zero_ff) ? pfin_ff : 32'd0;
         out_zero_ff <= kind_ff & zero_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (cmd.emit) begin
         out_valid_ff <= 1'b1;
      end else if (rsp_if.ready) begin
         out_valid_ff <= 1'b0;
      end
   end

   always_comb begin
      status.mul_done = mul_done;
      status.div_done = div_done;
      status.den_zero = den_zero;
      status.out_free = !out_valid_ff || rsp_if.ready;
   end

   assign rsp_if.valid = out_valid_ff;
   assign rsp_if.result_kind = out_kind_ff;
   assign rsp_if.temperature_hundredths = out_temp_ff;
   assign rsp_if.pressure_q8 = out_press_ff;
   assign rsp_if.zero_divisor = out_zero_ff;
endmodule

// File: rtl/ptc_ctrl.sv
// Controller that steps one sample through the multiply and divide sequence.
`timescale 1ns / 1ps
module ptc_ctrl (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   input  logic                req_kind,
   output logic                req_ready,
   input  ptc_pkg::status_type status,
   output ptc_pkg::cmd_type    cmd
);
   import ptc_pkg::*;

   localparam logic [1:0] S_IDLE = 2'd0;
   localparam logic [1:0] S_ISSUE = 2'd1;
   localparam logic [1:0] S_WAIT = 2'd2;
   localparam logic [1:0] S_DONE = 2'd3;

   logic [1:0] state_ff, state_in;
   logic [STEP_WIDTH-1:0] step_ff, step_in;
   logic op_done, last;

   assign op_done = (step_ff == STEP_P7) ? status.div_done : status.mul_done;
   assign last = (step_ff == STEP_T2) || (step_ff == STEP_P10)
                 || (step_ff == STEP_P5 && status.den_zero);
   assign req_ready = (state_ff == S_IDLE);

   always_comb begin
      state_in = state_ff;
      step_in = step_ff;
      cmd = '0;
      cmd.step = step_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               cmd.load = 1'b1;
               step_in = req_kind ? STEP_P0 : STEP_T0;
               state_in = S_ISSUE;
            end
         end
         S_ISSUE: begin
            cmd.start_div = (step_ff == STEP_P7);
            cmd.start_mul = (step_ff != STEP_P7);
            state_in = S_WAIT;
         end
         S_WAIT: begin
            if (op_done) begin
               cmd.write_back = 1'b1;
               if (last) begin
                  state_in = S_DONE;
               end else begin
                  step_in = step_ff + 4'd1;
                  state_in = S_ISSUE;
               end
            end
         end
         S_DONE: begin
            if (status.out_free) begin
               cmd.emit = 1'b1;
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         step_ff <= STEP_T0;
      end else begin
         state_ff <= state_in;
         step_ff <= step_in;
      end
   end
endmodule

// File: rtl/pressure_temperature_compensation.sv
// Top level of the barometric pressure and temperature compensation block.
// One sample is handled at a time. A temperature transaction uses the shared multiplier three
// times; a pressure transaction uses it ten times and the bit-serial divider once.
// A pressure transaction with a zero denominator ends after six products.
// A new transaction is accepted as soon as the previous result has been moved to the output
// register.
`timescale 1ns / 1ps
module pressure_temperature_compensation (
   input  logic                                 clock,
   input  logic                                 reset,
   ptc_req_if.sink                              req_if,
   ptc_rsp_if.source                            rsp_if,
   input  logic                                 csr_we,
   input  logic [ptc_pkg::CSR_INDEX_WIDTH-1:0]  csr_index,
   input  logic [ptc_pkg::CSR_WIDTH-1:0]        csr_wdata
);
   import ptc_pkg::*;

   cmd_type cmd;
   status_type status;

   ptc_ctrl u_ctrl (
      .clock(clock), .reset(reset), .req_valid(req_if.valid), .req_kind(req_if.kind),
      .req_ready(req_if.ready), .status(status), .cmd(cmd)
   );

   ptc_datapath u_datapath (
      .clock(clock), .reset(reset), .cmd(cmd), .status(status), .req_kind(req_if.kind),
      .req_raw_sample(req_if.raw_sample), .csr_we(csr_we), .csr_index(csr_index),
      .csr_wdata(csr_wdata), .rsp_if(rsp_if)
   );
endmodule

// File: test/tb_pressure_temperature_compensation.sv
// Testbench that checks the pressure and temperature compensation block against its own predictor.
`timescale 1ns / 1ps
module tb_pressure_temperature_compensation;
   import ptc_pkg::*;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic csr_we = 1'b0;
   logic [CSR_INDEX_WIDTH-1:0] csr_index = '0;
   logic [CSR_WIDTH-1:0] csr_wdata = '0;

   ptc_req_if req_if();
   ptc_rsp_if rsp_if();

   pressure_temperature_compensation dut (
      .clock(clock), .reset(reset), .req_if(req_if), .rsp_if(rsp_if),
      .csr_we(csr_we), .csr_index(csr_index), .csr_wdata(csr_wdata)
   );

   typedef struct packed {
      logic kind;
      logic signed [15:0] temp;
      logic [31:0] press;
      logic zero;
   } reading_type;

   logic [47:0] temp_cal;
   logic [63:0] press_cal_a;
   logic [63:0] press_cal_b;
   logic [15:0] press_cal_c;
   logic signed [31:0] fine_temp;

   reading_type expected_readings[$];
   int mismatches = 0;
   int results_seen = 0;
   int temp_count = 0;
   int press_count = 0;
   int zero_count = 0;
   int idle_cycles = 0;
   bit timed_out = 0;
   bit hold_off = 0;
   bit rsp_random = 1;

   localparam int WATCHDOG_LIMIT = 20000;

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   initial begin
      req_if.valid = 1'b0;
      req_if.kind = 1'b0;
      req_if.raw_sample = '0;
      rsp_if.ready = 1'b0;
   end

   function automatic logic signed [63:0] sx16(logic [15:0] w);
      return {{48{w[15]}}, w};
   endfunction

   function automatic logic signed [63:0] quot_trunc(logic signed [63:0] a,
                                                       logic signed [63:0] b);
      logic [63:0] ua, ub, q;
      ua = a[63] ? -a : a;
      ub = b[63] ? -b : b;
      q = ua / ub;
      return (a[63] != b[63]) ? -q : q;
   endfunction

   function automatic reading_type compensate(logic kind, logic [19:0] adc);
      reading_type r;
      logic signed [63:0] s_adc, t1, t2, t3, v1, v2, d, tf, t, p;
      logic signed [63:0] p1, p2, p3, p4, p5, p6, p7, p8, p9;
      r = '0;
      r.kind = kind;
      s_adc = {44'd0, adc};
      if (!kind) begin
         t1 = {48'd0, temp_cal[15:0]};
         t2 = sx16(temp_cal[31:16]);
         t3 = sx16(temp_cal[47:32]);
         v1 = (((s_adc >>> 3) - (t1 <<< 1)) * t2) >>> 11;
         d = (s_adc >>> 4) - t1;
         v2 = (((d * d) >>> 12) * t3) >>> 14;
         tf = v1 + v2;
         fine_temp = tf[31:0];
         t = fine_temp;
         t = (t * 5 + 128) >>> 8;
         if (t > 32767) t = 32767;
         if (t < -32768) t = -32768;
         r.temp = t[15:0];
      end else begin
         p1 = {48'd0, press_cal_a[15:0]};
         p2 = sx16(press_cal_a[31:16]);
         p3 = sx16(press_cal_a[47:32]);
         p4 = sx16(press_cal_a[63:48]);
         p5 = sx16(press_cal_b[15:0]);
         p6 = sx16(press_cal_b[31:16]);
         p7 = sx16(press_cal_b[47:32]);
         p8 = sx16(press_cal_b[63:48]);
         p9 = sx16(press_cal_c);
         v1 = {{32{fine_temp[31]}}, fine_temp} - 128000;
         v2 = v1 * v1 * p6;
         v2 = v2 + ((v1 * p5) <<< 17);
         v2 = v2 + (p4 <<< 35);
         v1 = ((v1 * v1 * p3) >>> 8) + ((v1 * p2) <<< 12);
         v1 = (((64'sd1 <<< 47) + v1) * p1) >>> 33;
         if (v1 == 0) begin
            r.zero = 1'b1;
         end else begin
            p = 64'sd1048576 - s_adc;
            p = quot_trunc(((p <<< 31) - v2) * 3125, v1);
            v1 = (p9 * (p >>> 13) * (p >>> 13)) >>> 25;
            v2 = (p8 * p) >>> 19;
            p = ((p + v1 + v2) >>> 8) + (p7 <<< 4);
            r.press = p[31:0];
         end
      end
      return r;
   endfunction

   function automatic int gap_length();
      int n;
      n = $urandom_range(0, 99);
      if (n < 55) n = 0;
      else if (n < 95) n = $urandom_range(1, 4);
      else n = $urandom_range(20, 150);
      return n;
   endfunction

   // The valid line stays high after an accepted transaction until a gap or a drain lowers it.
   task automatic send_sample(logic kind, logic [19:0] adc, bit gaps = 1);
      int n;
      n = gaps ? gap_length() : 0;
      if (n > 0) begin
         req_if.valid <= 1'b0;
         repeat (n) @(posedge clock);
      end
      req_if.valid <= 1'b1;
      req_if.kind <= kind;
      req_if.raw_sample <= adc;
      expected_readings.push_back(compensate(kind, adc));
      do @(posedge clock); while (!req_if.ready);
   endtask

   task automatic wait_drained();
      req_if.valid <= 1'b0;
      while (expected_readings.size() != 0) @(posedge clock);
      repeat (150) @(posedge clock);
   endtask

   task automatic write_cal(logic [CSR_INDEX_WIDTH-1:0] idx, logic [63:0] value);
      csr_we <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      @(posedge clock);
      csr_we <= 1'b0;
      @(posedge clock);
      case (idx)
         CSR_TEMP_CAL: temp_cal = value[47:0];
         CSR_PRESS_CAL_A: press_cal_a = value;
         CSR_PRESS_CAL_B: press_cal_b = value;
         CSR_PRESS_CAL_C: press_cal_c = value[15:0];
      endcase
   endtask

   task automatic load_typical();
      write_cal(CSR_TEMP_CAL, {16'd0, 16'hFC18, 16'd26435, 16'd27504});
      write_cal(CSR_PRESS_CAL_A, {16'h2AC3, 16'd3024, 16'hD5AA, 16'd36477});
      write_cal(CSR_PRESS_CAL_B, {16'h0BE8, 16'hC001, 16'hFFF9, 16'd140});
      write_cal(CSR_PRESS_CAL_C, 64'd6000);
   endtask

   task automatic test_before_temperature();
      send_sample(1'b1, 20'd415148);
      send_sample(1'b1, 20'hFFFFF);
      wait_drained();
   endtask

   task automatic test_zero_divisor();
      // With P1 cleared the denominator is zero.
      send_sample(1'b0, 20'd519888);
      send_sample(1'b1, 20'd0);
      send_sample(1'b1, 20'd415148);
      wait_drained();
   endtask

   task automatic test_directed_typical();
      load_typical();
      send_sample(1'b1, 20'd415148);
      send_sample(1'b0, 20'd519888);
      send_sample(1'b1, 20'd415148);
      send_sample(1'b0, 20'd0);
      send_sample(1'b1, 20'd0);
      send_sample(1'b0, 20'hFFFFF);
      send_sample(1'b1, 20'hFFFFF);
      send_sample(1'b1, 20'h55555);
      send_sample(1'b0, 20'hAAAAA);
      wait_drained();
   endtask

   task automatic test_extreme_cal();
      // Saturating temperatures and wrapping pressure intermediates.
      write_cal(CSR_TEMP_CAL, {16'd0, 16'h7FFF, 16'h7FFF, 16'h0000});
      write_cal(CSR_PRESS_CAL_A, 64'hFFFF_FFFF_FFFF_FFFF);
      write_cal(CSR_PRESS_CAL_B, 64'h8000_8000_8000_8000);
      write_cal(CSR_PRESS_CAL_C, 64'h8000);
      send_sample(1'b0, 20'hFFFFF);
      send_sample(1'b1, 20'd0);
      send_sample(1'b1, 20'hFFFFF);
      wait_drained();
      write_cal(CSR_TEMP_CAL, {16'd0, 16'h8000, 16'h7FFF, 16'hFFFF});
      write_cal(CSR_PRESS_CAL_A, 64'h7FFF_7FFF_7FFF_FFFF);
      write_cal(CSR_PRESS_CAL_B, 64'h7FFF_7FFF_7FFF_7FFF);
      write_cal(CSR_PRESS_CAL_C, 64'h7FFF);
      send_sample(1'b0, 20'd0);
      send_sample(1'b1, 20'h80000);
      send_sample(1'b0, 20'hFFFFF);
      send_sample(1'b1, 20'd1);
      wait_drained();
   endtask

   task automatic test_random(int count, bit random_cal);
      logic [19:0] adc;
      for (int i = 0; i < count; i++) begin
         if ($urandom_range(0, 3) == 0) adc = 20'($urandom);
         else adc = 20'($urandom_range(300000, 600000));
         send_sample(1'($urandom_range(0, 1)), adc);
      end
      wait_drained();
      if (random_cal) begin
         write_cal(CSR_TEMP_CAL, {$urandom, $urandom});
         write_cal(CSR_PRESS_CAL_A, {$urandom, $urandom});
         write_cal(CSR_PRESS_CAL_B, {$urandom, $urandom});
         write_cal(CSR_PRESS_CAL_C, {$urandom, $urandom});
      end
   endtask

   task automatic test_backpressure();
      hold_off = 1'b1;
      fork
         begin
            repeat (400) @(posedge clock);
            hold_off = 1'b0;
         end
         for (int i = 0; i < 6; i++) begin
            send_sample(1'($urandom_range(0, 1)), 20'($urandom), 0);
         end
      join
      wait_drained();
   endtask

   always @(posedge clock) begin
      if (reset || hold_off) rsp_if.ready <= 1'b0;
      else if (!rsp_random) rsp_if.ready <= 1'b1;
      else rsp_if.ready <= ($urandom_range(0, 99) < 70);
   end

   always @(posedge clock) begin
      reading_type exp_r;
      if (!reset && rsp_if.valid && rsp_if.ready) begin
         results_seen++;
         if (expected_readings.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) $display("ERROR: unexpected result transaction");
         end else begin
            exp_r = expected_readings.pop_front();
            if (exp_r.kind) press_count++; else temp_count++;
            if (exp_r.zero) zero_count++;
            if (rsp_if.result_kind !== exp_r.kind || rsp_if.temperature_hundredths !== exp_r.temp
                || rsp_if.pressure_q8 !== exp_r.press || rsp_if.zero_divisor !== exp_r.zero) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("ERROR: expected kind %0d temp %0d press %0h zero %0d, got %0d %0d %0h %0d",
                           exp_r.kind, exp_r.temp, exp_r.press, exp_r.zero,
                           rsp_if.result_kind, rsp_if.temperature_hundredths,
                           rsp_if.pressure_q8, rsp_if.zero_divisor);
            end
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready))
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
   end

   initial begin
      temp_cal = '0;
      press_cal_a = '0;
      press_cal_b = '0;
      press_cal_c = '0;
      fine_temp = '0;
      fork
         begin
            repeat (10) @(posedge clock);
            reset <= 1'b0;
            @(posedge clock);
            test_before_temperature();
            test_zero_divisor();
            test_directed_typical();
            test_extreme_cal();
            load_typical();
            test_backpressure();
            rsp_random = 0;
            test_random(60, 0);
            rsp_random = 1;
            test_random(200, 0);
            test_random(60, 1);
            test_random(60, 1);
            load_typical();
            test_random(50, 0);
         end
         begin
            wait (idle_cycles >= WATCHDOG_LIMIT);
            timed_out = 1;
         end
      join_any
      if (timed_out) begin
         $display("Test completed with failures");
         $finish;
      end
      if (expected_readings.size() != 0) mismatches++;
      $display("Covered %0d results: %0d temperature, %0d pressure, %0d zero divisor.",
               results_seen, temp_count, press_count, zero_count);
      $display("Calibration sets included reset, typical, extreme and random values.");
      if (mismatches == 0) begin
         $display("Test completed successfully");
      end else begin
         $display("Test completed with failures");
      end
      $finish;
   end
endmodule

// File: pressure_temperature_compensation.f
rtl/ptc_pkg.sv
rtl/ptc_req_if.sv
rtl/ptc_rsp_if.sv
rtl/ptc_mul.sv
rtl/ptc_div.sv
rtl/ptc_datapath.sv
rtl/ptc_ctrl.sv
rtl/pressure_temperature_compensation.sv
test/tb_pressure_temperature_compensation.sv
